// ===== sv/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Delimited packet deframer package
// Shared state, command and status types and register constants.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] HeaderReset = 8'd36;
  localparam logic [7:0] EndReset    = 8'd35;

  typedef enum logic {
    REG_HEADER = 1'b0,
    REG_END    = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic clear_body;
    logic store_byte;
    logic set_ovf;
    logic rd_first;
    logic rd_next;
    logic load_out;
    logic load_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic is_header;
    logic is_end;
    logic count_zero;
    logic count_full;
    logic out_last;
  } dp_status_t;

endpackage

// ===== sv/dpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 12
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deframer controller
// Hunts for a header, collects the body and sequences the frame readout.
// ----------------------------------------------------------------------------
module dpd_ctrl
  import dpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_HUNT: begin
        in_ready_o = 1'b1;
        if (in_valid_i && status_i.is_header) begin
          cmd_o.clear_body = 1'b1;
          state_d          = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.is_end) begin
            if (status_i.count_zero) begin
              cmd_o.load_empty = 1'b1;
              state_d          = ST_SEND;
            end else begin
              cmd_o.rd_first = 1'b1;
              state_d        = ST_FETCH;
            end
          end else if (status_i.is_header) begin
            cmd_o.clear_body = 1'b1;
          end else if (!status_i.count_full) begin
            cmd_o.store_byte = 1'b1;
          end else begin
            cmd_o.set_ovf = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = ST_HUNT;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

endmodule

// ===== sv/dpd_dp.sv =====
// ----------------------------------------------------------------------------
// Deframer datapath
// Delimiter registers, body store, counters and the result register.
// ----------------------------------------------------------------------------
module dpd_dp
  import dpd_pkg::*;
#(
  parameter int MAX_BODY = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic [7:0] rx_byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic [7:0] body_byte_o,
  output logic       last_byte_o,
  output logic       empty_frame_o,
  output logic [3:0] frame_length_o,
  output logic       truncated_o
);

  localparam int CntW  = $clog2(MAX_BODY + 1);
  localparam int AddrW = MAX_BODY > 1 ? $clog2(MAX_BODY) : 1;

  logic [7:0]      header_q, end_q;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      byte_q;
  logic            last_q, empty_q, trunc_q;
  logic [3:0]      len_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]      rd_data;
  logic [CntW+3:0] count_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      end_q    <= EndReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HEADER: header_q <= cfg_data_i;
        REG_END:    end_q    <= cfg_data_i;
        default:    header_q <= header_q;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    if (cmd_i.clear_body) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.store_byte) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.rd_first) begin
      idx_d = CntW'(1);
    end else if (cmd_i.rd_next) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
    end
  end

  assign rd_en     = cmd_i.rd_first | cmd_i.rd_next;
  assign rd_addr   = cmd_i.rd_first ? '0 : idx_q[AddrW-1:0];
  assign count_ext = {4'b0000, count_q};

  dpd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BODY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_byte),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_empty) begin
      byte_q  <= 8'd0;
      last_q  <= 1'b1;
      empty_q <= 1'b1;
      len_q   <= 4'd0;
      trunc_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      byte_q  <= rd_data;
      last_q  <= (idx_q == count_q);
      empty_q <= 1'b0;
      len_q   <= count_ext[3:0];
      trunc_q <= ovf_q;
    end
  end

  assign status_o.is_header  = (rx_byte_i == header_q);
  assign status_o.is_end     = (rx_byte_i == end_q);
  assign status_o.count_zero = (count_q == '0);
  assign status_o.count_full = (count_q >= CntW'(MAX_BODY));
  assign status_o.out_last   = last_q;

  assign body_byte_o    = byte_q;
  assign last_byte_o    = last_q;
  assign empty_frame_o  = empty_q;
  assign frame_length_o = len_q;
  assign truncated_o    = trunc_q;

endmodule

// ===== sv/delimited_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// Delimited packet deframer
// Collects the body between a header byte and an end byte and emits it.
// ----------------------------------------------------------------------------
// Each received byte is taken as soon as it is offered while hunting or
// collecting; bytes are refused during readout. After the end byte, each
// result takes a body store read, then a load of the result register.
// An empty frame gives its single result in the cycle after the end byte.
// Reset selects '$' as header and '#' as end and starts hunting; the body
// store is not cleared.
module delimited_packet_deframer
  import dpd_pkg::*;
#(
  parameter int MAX_BODY = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] body_byte_o,
  output logic       last_byte_o,
  output logic       empty_frame_o,
  output logic [3:0] frame_length_o,
  output logic       truncated_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpd_dp #(
    .MAX_BODY(MAX_BODY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .body_byte_o   (body_byte_o),
    .last_byte_o   (last_byte_o),
    .empty_frame_o (empty_frame_o),
    .frame_length_o(frame_length_o),
    .truncated_o   (truncated_o)
  );

endmodule

// ===== tb/sv/dpd_frame_monitor.sv =====
// ----------------------------------------------------------------------------
// Delimited packet deframer frame monitor
// Watches the register port and both request channels, keeps its own model of
// the framing state and the body store, and queues the results that each
// accepted byte should produce. Every result request is checked against the
// oldest queued result; surprises and mismatches are counted for the top.
// ----------------------------------------------------------------------------
module dpd_frame_monitor
  import dpd_pkg::*;
#(
  parameter int MAX_BODY = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] body_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_frame_i,
  input  logic [3:0] frame_length_i,
  input  logic       truncated_i,
  output int         mismatch_count_o,
  output int         pending_results_o
);

  localparam int PrintLimit = 50;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
    logic       empty_frame;
    logic [3:0] frame_length;
    logic       truncated;
  } frame_result_t;

  frame_result_t expected_results_q[$];

  logic [7:0]  header_char_q;
  logic [7:0]  end_char_q;
  logic        in_frame_q;
  int unsigned body_count_q;
  logic        overflow_q;
  logic [7:0]  body_store_q[MAX_BODY];

  function automatic string fmt_result(input frame_result_t r);
    return $sformatf("byte=%02h last=%0d empty=%0d len=%0d trunc=%0d", r.body_byte,
                     r.last_byte, r.empty_frame, r.frame_length, r.truncated);
  endfunction

  task automatic predict_rx_byte(input logic [7:0] b);
    frame_result_t r;
    if (!in_frame_q) begin
      if (b == header_char_q) begin
        in_frame_q   = 1'b1;
        body_count_q = 0;
        overflow_q   = 1'b0;
      end
    end else if (b == end_char_q) begin
      if (body_count_q == 0) begin
        r.body_byte    = 8'h00;
        r.last_byte    = 1'b1;
        r.empty_frame  = 1'b1;
        r.frame_length = 4'd0;
        r.truncated    = 1'b0;
        expected_results_q.push_back(r);
      end else begin
        for (int k = 0; k < body_count_q; k++) begin
          r.body_byte    = body_store_q[k];
          r.last_byte    = (k + 1 == body_count_q);
          r.empty_frame  = 1'b0;
          r.frame_length = 4'(body_count_q);
          r.truncated    = overflow_q;
          expected_results_q.push_back(r);
        end
      end
      in_frame_q   = 1'b0;
      body_count_q = 0;
      overflow_q   = 1'b0;
    end else if (b == header_char_q) begin
      body_count_q = 0;
      overflow_q   = 1'b0;
    end else if (body_count_q < MAX_BODY) begin
      body_store_q[body_count_q] = b;
      body_count_q++;
    end else begin
      overflow_q = 1'b1;
    end
  endtask

  // Inputs only change at the rising edge, so the values seen at the falling
  // edge are the ones that the following rising edge acts on.
  always @(negedge clk_i or negedge rst_ni) begin : sample_channels
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      header_char_q     = HeaderReset;
      end_char_q        = EndReset;
      in_frame_q        = 1'b0;
      body_count_q      = 0;
      overflow_q        = 1'b0;
      mismatch_count_o  = 0;
      pending_results_o = 0;
      expected_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.body_byte    = body_byte_i;
        got.last_byte    = last_byte_i;
        got.empty_frame  = empty_frame_i;
        got.frame_length = frame_length_i;
        got.truncated    = truncated_i;
        if (expected_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= PrintLimit) begin
            $display("%0t: unexpected result, expected none, actual %s", $time,
                     fmt_result(got));
          end
        end else begin
          want = expected_results_q.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= PrintLimit) begin
              $display("%0t: result mismatch, expected %s, actual %s", $time,
                       fmt_result(want), fmt_result(got));
            end
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_HEADER) begin
          header_char_q = cfg_data_i;
        end else begin
          end_char_q = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_rx_byte(rx_byte_i);
      end
      pending_results_o = expected_results_q.size();
    end
  end

endmodule

// ===== tb/sv/delimited_packet_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// Delimited packet deframer testbench
// Drives received bytes under random gaps and result back-pressure: a short
// directed run of empty, restarted and overflowing frames, then random frames
// under several header and end byte settings, extremes and equal bytes among
// them. The frame monitor predicts and checks every result request.
// ----------------------------------------------------------------------------
module delimited_packet_deframer_tb;
  import dpd_pkg::*;

  localparam int MaxBody     = 12;
  localparam int QuietCycles = 40;
  localparam int DrainLimit  = 20000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] body_byte_o;
  logic       last_byte_o;
  logic       empty_frame_o;
  logic [3:0] frame_length_o;
  logic       truncated_o;

  int         mismatch_count;
  int         pending_results;
  logic [7:0] header_q;
  logic [7:0] end_q;

  delimited_packet_deframer #(
    .MAX_BODY(MaxBody)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .body_byte_o,
    .last_byte_o,
    .empty_frame_o,
    .frame_length_o,
    .truncated_o
  );

  dpd_frame_monitor #(
    .MAX_BODY(MaxBody)
  ) u_frame_mon (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .rx_byte_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .body_byte_i      (body_byte_o),
    .last_byte_i      (last_byte_o),
    .empty_frame_i    (empty_frame_o),
    .frame_length_i   (frame_length_o),
    .truncated_i      (truncated_o),
    .mismatch_count_o (mismatch_count),
    .pending_results_o(pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  initial begin
    int g;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int g;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_HEADER) header_q = value;
    else end_q = value;
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (pending_results != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_results != 0) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      repeat (QuietCycles) @(posedge clk_i);
    end
  endtask

  // Mostly complete frames with random bodies; some line noise and some frames
  // that are left open so that the next header restarts them.
  task automatic run_traffic(input int budget);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, MaxBody)
                                          : $urandom_range(MaxBody + 1, MaxBody + 8);
        push_byte(header_q);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 24) == 0) push_byte(header_q);
          else push_byte(8'($urandom_range(0, 255)));
        end
        if (kind < 85) push_byte(end_q);
        sent += len + 2;
      end
    end
  endtask

  initial begin
    logic [7:0] h;
    logic [7:0] e;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_HEADER;
    cfg_data_i <= 8'h00;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    header_q    = HeaderReset;
    end_q       = EndReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_byte(8'hFF);
    push_byte(end_q);
    push_byte(header_q);
    push_byte(end_q);
    push_byte(header_q);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(end_q);
    push_byte(header_q);
    push_byte(8'h11);
    push_byte(header_q);
    push_byte(8'h22);
    push_byte(end_q);
    push_byte(header_q);
    for (int i = 0; i < MaxBody + 1; i++) push_byte(8'(8'h40 + i));
    push_byte(end_q);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          h = 8'h00;
          e = 8'hFF;
        end
        1: begin
          h = 8'hFF;
          e = 8'h00;
        end
        2: begin
          h = 8'($urandom_range(0, 255));
          e = h;
        end
        3: begin
          h = 8'($urandom_range(0, 255));
          e = 8'($urandom_range(0, 255));
        end
        default: begin
          h = HeaderReset;
          e = EndReset;
        end
      endcase
      write_reg(REG_HEADER, h);
      write_reg(REG_END, e);
      run_traffic(100);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dpd_pkg.sv
sv/dpd_ram.sv
sv/dpd_ctrl.sv
sv/dpd_dp.sv
sv/delimited_packet_deframer.sv
tb/sv/dpd_frame_monitor.sv
tb/sv/delimited_packet_deframer_tb.sv
